@@ hw/rtl/seghit_pkg.sv @@
// Shared types, constants and arithmetic helpers for the segment/circle hit test.
`timescale 1ns / 1ps

package seghit_pkg;

  localparam int CoordW  = 16;          // coordinate and centre width
  localparam int RadiusW = 15;          // radius width
  localparam int DiffW   = CoordW + 1;  // start-relative differences
  localparam int WideW   = 34;          // dot product, squared lengths, split operands
  localparam int HalfW   = WideW / 2;   // partial product operand width
  localparam int ProdW   = 2 * WideW;   // full product width
  localparam int NumStg  = 7;           // stages ahead of the output register

  localparam int CfgIdxW = 2;
  localparam int InDataW = 4 * CoordW;
  localparam int OutDataW = 8;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_CENTER_X = 2'd0,
    CFG_CENTER_Z = 2'd1,
    CFG_RADIUS   = 2'd2
  } cfg_idx_t;

  // Four partial products of a split WideW x WideW multiply.
  typedef struct packed {
    logic [WideW-1:0] ll;
    logic [WideW-1:0] lh;
    logic [WideW-1:0] hl;
    logic [WideW-1:0] hh;
  } part_t;

  function automatic part_t mul_parts(logic [WideW-1:0] a, logic [WideW-1:0] b);
    part_t p;
    p.ll = a[HalfW-1:0]     * b[HalfW-1:0];
    p.lh = a[HalfW-1:0]     * b[WideW-1:HalfW];
    p.hl = a[WideW-1:HalfW] * b[HalfW-1:0];
    p.hh = a[WideW-1:HalfW] * b[WideW-1:HalfW];
    return p;
  endfunction

  function automatic logic [ProdW-1:0] join_parts(part_t p);
    logic [ProdW-1:0] sum;
    sum = {{WideW{1'b0}}, p.ll}
        + {{HalfW{1'b0}}, p.lh, {HalfW{1'b0}}}
        + {{HalfW{1'b0}}, p.hl, {HalfW{1'b0}}}
        + {p.hh, {WideW{1'b0}}};
    return sum;
  endfunction

endpackage

@@ hw/rtl/segment_circle_hit_test.sv @@
// Pipelined segment versus circle hit test in the X/Z plane.
`timescale 1ns / 1ps

// Takes one segment per cycle on the slave stream while s_tready is high and
// returns one hit flag per segment on the master stream, in order. Each
// segment passes through seven register stages
// (differences, 17x17 products, sums, wide subtracts, negate/flags, split
// 17x17 partial products, product assembly) and the output register, which
// holds the final 68-bit compares. Each stage has its own valid bit and loads
// whenever it is empty or its successor moves, so backpressure fills bubbles
// before it reaches s_tready. A hit needs the segment to head toward the
// centre, to be long enough to reach the circle, and a nonnegative
// discriminant; all math is exact integer. Configuration writes are always
// taken (cfg_ready is tied high) and should be issued only while the pipeline
// is empty; an index beyond the radius register is ignored.
module segment_circle_hit_test
  import seghit_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  // config write channel
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CoordW-1:0]   cfg_data,
  // segment items in
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [InDataW-1:0]  s_tdata,   // start_x, start_z, end_x, end_z (low to high)
  // hit items out
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [OutDataW-1:0] m_tdata    // hit, then zero fill
);

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic signed [CoordW-1:0] center_x;
  logic signed [CoordW-1:0] center_z;
  logic        [RadiusW-1:0] radius;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      center_x <= '0;
      center_z <= '0;
      radius   <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_CENTER_X: center_x <= cfg_data;
        CFG_CENTER_Z: center_z <= cfg_data;
        CFG_RADIUS:   radius   <= cfg_data[RadiusW-1:0];
        default: ;  // unused index: drop the write
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Pipeline flow control: a stage loads when it is empty or its successor
  // loads. en[NumStg+1] belongs to the output register.
  // ---------------------------------------------------------------------------
  logic [NumStg:1]   vld;
  logic [NumStg+1:1] en;

  always_comb begin
    en[NumStg+1] = !m_tvalid || m_tready;
    for (int k = NumStg; k >= 1; k--) begin
      en[k] = !vld[k] || en[k+1];
    end
  end

  assign s_tready = en[1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[1]) vld[1] <= s_tvalid;
      for (int k = 2; k <= NumStg; k++) begin
        if (en[k]) vld[k] <= vld[k-1];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: direction and start-to-centre vectors
  // ---------------------------------------------------------------------------
  logic signed [CoordW-1:0] in_sx, in_sz, in_ex, in_ez;
  logic signed [DiffW-1:0]  rx, rz, dx, dz;

  assign in_sx = s_tdata[CoordW-1:0];
  assign in_sz = s_tdata[2*CoordW-1:CoordW];
  assign in_ex = s_tdata[3*CoordW-1:2*CoordW];
  assign in_ez = s_tdata[4*CoordW-1:3*CoordW];

  always_ff @(posedge clk) begin
    if (en[1]) begin
      rx <= {center_x[CoordW-1], center_x} - {in_sx[CoordW-1], in_sx};
      rz <= {center_z[CoordW-1], center_z} - {in_sz[CoordW-1], in_sz};
      dx <= {in_ex[CoordW-1], in_ex} - {in_sx[CoordW-1], in_sx};
      dz <= {in_ez[CoordW-1], in_ez} - {in_sz[CoordW-1], in_sz};
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: component products and r^2
  // ---------------------------------------------------------------------------
  logic signed [2*DiffW-1:0] p_drx, p_drz, p_rrx, p_rrz, p_ddx, p_ddz;
  logic [2*RadiusW-1:0]      r2_s2;

  always_ff @(posedge clk) begin
    if (en[2]) begin
      p_drx <= dx * rx;
      p_drz <= dz * rz;
      p_rrx <= rx * rx;
      p_rrz <= rz * rz;
      p_ddx <= dx * dx;
      p_ddz <= dz * dz;
      r2_s2 <= radius * radius;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 3: dot product D, squared distance C, squared length L
  // ---------------------------------------------------------------------------
  logic signed [WideW:0]  dot_s3;
  logic [WideW-1:0]       cdist_s3, llen_s3;
  logic [2*RadiusW-1:0]   r2_s3;

  always_ff @(posedge clk) begin
    if (en[3]) begin
      dot_s3   <= {p_drx[2*DiffW-1], p_drx} + {p_drz[2*DiffW-1], p_drz};
      // squares are nonnegative: drop the sign bit and add unsigned
      cdist_s3 <= {1'b0, p_rrx[2*DiffW-2:0]} + {1'b0, p_rrz[2*DiffW-2:0]};
      llen_s3  <= {1'b0, p_ddx[2*DiffW-2:0]} + {1'b0, p_ddz[2*DiffW-2:0]};
      r2_s3    <= r2_s2;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 4: A = L - C - r^2, c = C - r^2, direction check
  // ---------------------------------------------------------------------------
  logic signed [WideW+1:0] diff_s4;
  logic signed [WideW:0]   cterm_s4;
  logic                    dot_pos_s4;
  logic [WideW-1:0]        dot_s4, cdist_s4, llen_s4, r4_s4;

  always_ff @(posedge clk) begin
    if (en[4]) begin
      diff_s4    <= {2'b00, llen_s3} - {2'b00, cdist_s3}
                  - {{(WideW+2-2*RadiusW){1'b0}}, r2_s3};
      cterm_s4   <= {1'b0, cdist_s3} - {{(WideW+1-2*RadiusW){1'b0}}, r2_s3};
      dot_pos_s4 <= !dot_s3[WideW] && (dot_s3 != '0);
      dot_s4     <= dot_s3[WideW-1:0];
      cdist_s4   <= cdist_s3;
      llen_s4    <= llen_s3;
      // 4*r^2 as a shift, zero extended to the split operand width
      r4_s4      <= {{(WideW-2*RadiusW-2){1'b0}}, r2_s3, 2'b00};
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 5: -A (the magnitude of A when A is not positive), sign flags
  // ---------------------------------------------------------------------------
  logic [WideW+1:0] neg_diff;
  logic             dot_pos_s5, a_pos_s5, c_pos_s5;
  logic [WideW-1:0] mag_s5, cterm_s5, dot_s5, cdist_s5, llen_s5, r4_s5;

  assign neg_diff = -diff_s4;

  always_ff @(posedge clk) begin
    if (en[5]) begin
      a_pos_s5   <= !diff_s4[WideW+1] && (diff_s4 != '0);
      c_pos_s5   <= !cterm_s4[WideW] && (cterm_s4 != '0);
      mag_s5     <= neg_diff[WideW-1:0];
      cterm_s5   <= cterm_s4[WideW-1:0];
      dot_pos_s5 <= dot_pos_s4;
      dot_s5     <= dot_s4;
      cdist_s5   <= cdist_s4;
      llen_s5    <= llen_s4;
      r4_s5      <= r4_s4;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 6: 17x17 partial products of the four wide products
  // ---------------------------------------------------------------------------
  part_t pp_rc, pp_mm, pp_dd, pp_lc;
  logic  dot_pos_s6, a_pos_s6, c_pos_s6;

  always_ff @(posedge clk) begin
    if (en[6]) begin
      pp_rc      <= mul_parts(r4_s5, cdist_s5);    // 4*r^2*C
      pp_mm      <= mul_parts(mag_s5, mag_s5);     // A^2
      pp_dd      <= mul_parts(dot_s5, dot_s5);     // D^2
      pp_lc      <= mul_parts(llen_s5, cterm_s5);  // L*c
      dot_pos_s6 <= dot_pos_s5;
      a_pos_s6   <= a_pos_s5;
      c_pos_s6   <= c_pos_s5;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 7: assemble the full products
  // ---------------------------------------------------------------------------
  logic [ProdW-1:0] prod_rc, prod_mm, prod_dd, prod_lc;
  logic             dot_pos_s7, a_pos_s7, c_pos_s7;

  always_ff @(posedge clk) begin
    if (en[7]) begin
      prod_rc    <= join_parts(pp_rc);
      prod_mm    <= join_parts(pp_mm);
      prod_dd    <= join_parts(pp_dd);
      prod_lc    <= join_parts(pp_lc);
      dot_pos_s7 <= dot_pos_s6;
      a_pos_s7   <= a_pos_s6;
      c_pos_s7   <= c_pos_s6;
    end
  end

  // ---------------------------------------------------------------------------
  // Output register: final compares and the hit flag
  // ---------------------------------------------------------------------------
  logic reach_ok, disc_ok, hit_next;

  assign reach_ok = a_pos_s7 || (prod_rc > prod_mm);
  assign disc_ok  = !c_pos_s7 || (prod_dd >= prod_lc);
  assign hit_next = dot_pos_s7 && reach_ok && disc_ok;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (en[NumStg+1]) begin
      m_tvalid <= vld[NumStg];
    end
  end

  always_ff @(posedge clk) begin
    if (en[NumStg+1]) begin
      m_tdata <= {{(OutDataW-1){1'b0}}, hit_next};
    end
  end

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  // an accepted item lands in the first stage
  a_accept_lands: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> vld[1])
    else $error("accepted item missing from stage 1");

  // a full pipeline behind a stalled output refuses new items
  a_full_stalls: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready && (&vld) |-> !s_tready)
    else $error("input taken while pipeline full and stalled");

  // a segment heading away from the centre never reports a hit
  a_away_no_hit: assert property (@(posedge clk) disable iff (rst)
    vld[NumStg] && en[NumStg+1] && !dot_pos_s7 |=> m_tvalid && !m_tdata[0])
    else $error("hit reported with nonpositive direction dot product");

endmodule
